// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, disabled in reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/khts_pkg.sv =====
// Package for the k-mer hash table search block.
// Holds sequencer states and character code helper. No dependencies.
package khts_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_QLOAD, ST_HASH, ST_HREAD, ST_HWAIT, ST_INSERT, ST_CPY,
    ST_ENTRY, ST_CMP, ST_LINK, ST_DONE, ST_CLEAR
  } state_t;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;

  function automatic logic [2:0] char_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      CH_A:    r = 3'd0;
      CH_C:    r = 3'd1;
      CH_G:    r = 3'd2;
      CH_T:    r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction
endpackage

// ===== hdl/khts_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module khts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/khts_hash.sv =====
// Serial hash unit: one character per cycle while step is high, Horner form over base-5 pairs.
// Depends on khts_pkg.
module khts_hash #(
  parameter int FRAG_LEN = 16,
  parameter int BUCKETS  = 1024
) (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [7:0]                 ch,
  input  logic [$clog2(FRAG_LEN)-1:0] idx,
  output logic [$clog2(BUCKETS)-1:0] bucket
);
  import khts_pkg::*;
  localparam int BW = $clog2(BUCKETS);
  // sum is kept modulo BUCKETS; multiply by 5 between exponent groups
  logic [BW-1:0] acc;
  logic [BW+3:0] acc5;
  logic [BW+3:0] sum_w;
  logic [BW+3:0] red;
  logic          mul5;

  // exponent (L-i-1)/2 is one lower for index i than for i-1 when L-i-1 is
  // odd, so acc is multiplied by 5 before character i is added in that case
  assign mul5  = (((FRAG_LEN - 1 - int'(idx)) % 2) == 1);
  assign acc5  = mul5 ? ({4'd0, acc} * (BW+4)'(5)) : {4'd0, acc};
  assign sum_w = acc5 + (BW+4)'(char_code(ch));

  // sum_w stays below 5*BUCKETS: fold it back by subtracting the largest multiple of BUCKETS not above it
  always_comb begin
    priority if (sum_w >= (BW+4)'(4 * BUCKETS)) red = sum_w - (BW+4)'(4 * BUCKETS);
    else if (sum_w >= (BW+4)'(3 * BUCKETS)) red = sum_w - (BW+4)'(3 * BUCKETS);
    else if (sum_w >= (BW+4)'(2 * BUCKETS)) red = sum_w - (BW+4)'(2 * BUCKETS);
    else if (sum_w >= (BW+4)'(BUCKETS)) red = sum_w - (BW+4)'(BUCKETS);
    else red = sum_w;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (step) begin
      acc <= red[BW-1:0];
    end
  end
  assign bucket = acc;
endmodule

// ===== hdl/kmer_hash_table_search.sv =====
// Top level of the k-mer hash table search block.
// Depends on khts_pkg, khts_hash, khts_ram and assert_macros.svh.
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: ch[7:0]; tuser: func
// m_axis  | out | tdata: hit, position, matched_entry, collision_count,
//         |     |        hit_count, dropped (95 bits, padded to 96)
// Steps from an accepted item to its result: a query character that completes
// no fragment, a dropped fragment or a genome character before the window is
// full go straight to the output register; an inserted fragment is hashed,
// then copied into the store one byte a cycle; a genome search hashes the
// window, then compares each chain entry byte by byte through the single
// fragment store read port until a match ends the walk or the chain ends.
// After reset, a clearing pass empties the bucket heads; no item is taken
// meanwhile. The result waits in the output register; the next item is
// taken at the earliest the cycle after it has left.
`include "assert_macros.svh"
module kmer_hash_table_search #(
  parameter int FRAG_LEN  = 16,
  parameter int BUCKETS   = 1024,
  parameter int POOL_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // hit, position, matched_entry,
                                      // collision_count, hit_count, dropped
);
  import khts_pkg::*;
  localparam int LW = $clog2(FRAG_LEN);
  localparam int CW = $clog2(FRAG_LEN + 1);
  localparam int BW = $clog2(BUCKETS);
  localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int EW = $clog2(POOL_SIZE + 1);
  localparam int SW = PW + LW;
  localparam int PD = (POOL_SIZE > 1) ? POOL_SIZE : 2;
  localparam logic [35:0] MAX36 = '1;
  localparam logic [10:0] MAX11 = '1;

  state_t state, state_next;

  logic [7:0]    qbuf [FRAG_LEN];
  logic [7:0]    gwin [FRAG_LEN];
  logic [CW-1:0] qcnt;
  logic [EW-1:0] ecount;
  logic [35:0]   gpos, hits;
  logic [10:0]   coll;
  logic          func;
  logic [LW-1:0] cnt;
  logic [LW-1:0] cnt_d;
  logic          rd_vld;
  logic [BW-1:0] bkt;
  logic [PW-1:0] idx;
  logic          cur_valid;
  logic          byte_eq;
  logic          mismatch;
  logic [BW-1:0] clr_addr;

  // bucket head RAM: {valid, index}
  logic          h_we;
  logic [BW-1:0] h_waddr;
  logic [PW:0]   h_wdata, h_rdata;
  // link RAM: {valid, index}
  logic          l_we;
  logic [PW:0]   l_wdata, l_rdata;
  // fragment store
  logic          f_we;
  logic [SW-1:0] f_waddr, f_raddr;
  logic [7:0]    f_rdata;

  logic          hash_start, hash_step;
  logic [7:0]    hash_ch;
  logic [BW-1:0] hash_bkt;

  logic          r_hit, r_drop;
  logic [35:0]   r_pos;
  logic [PW-1:0] r_entry;
  logic [31:0]   entry_ext;

  logic          in_acc, out_stall;

  khts_hash #(.FRAG_LEN(FRAG_LEN), .BUCKETS(BUCKETS)) u_hash (
    .clk, .start(hash_start), .step(hash_step), .ch(hash_ch), .idx(cnt),
    .bucket(hash_bkt)
  );

  khts_ram #(.WIDTH(PW + 1), .DEPTH(BUCKETS)) u_head (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(bkt),
    .rdata(h_rdata)
  );
  khts_ram #(.WIDTH(PW + 1), .DEPTH(PD)) u_link (
    .clk, .we(l_we), .waddr(ecount[PW-1:0]), .wdata(l_wdata), .raddr(idx),
    .rdata(l_rdata)
  );
  khts_ram #(.WIDTH(8), .DEPTH(1 << SW)) u_frag (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(qbuf[cnt]), .raddr(f_raddr),
    .rdata(f_rdata)
  );

  assign hash_ch   = func ? gwin[cnt] : qbuf[cnt];
  assign f_waddr   = {ecount[PW-1:0], cnt};
  assign f_raddr   = {idx, cnt};
  assign h_wdata   = state == ST_CLEAR ? '0 : {1'b1, ecount[PW-1:0]};
  assign h_waddr   = state == ST_CLEAR ? clr_addr : bkt;
  assign l_wdata   = h_rdata;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  // pack the result item, highest field first
  assign entry_ext    = 32'(r_entry);
  assign m_axis_tdata = {1'b0, r_drop, hits, coll, entry_ext[9:0], r_pos, r_hit};

  // compare byte cnt_d, which arrives in the cycle after its address
  assign byte_eq = (f_rdata == gwin[cnt_d]);

  always_comb begin
    state_next = state;
    hash_start = 1'b0;
    hash_step  = 1'b0;
    h_we = 1'b0;
    l_we = 1'b0;
    f_we = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        h_we = 1'b1;
        if (clr_addr == BW'(BUCKETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_QLOAD;
      ST_QLOAD: begin
        hash_start = 1'b1;
        // decide whether a hash is needed
        if (func ? (gpos >= 36'(FRAG_LEN)) :
            (qcnt == CW'(FRAG_LEN) && ecount < EW'(POOL_SIZE)))
          state_next = ST_HASH;
        else
          state_next = ST_DONE;
      end
      ST_HASH: begin
        hash_step = 1'b1;
        if (cnt == LW'(FRAG_LEN - 1)) state_next = ST_HREAD;
      end
      ST_HREAD: state_next = ST_HWAIT;
      ST_HWAIT: state_next = func ? ST_ENTRY : ST_INSERT;
      ST_INSERT: begin
        h_we = 1'b1;
        l_we = 1'b1;
        state_next = ST_CPY;
      end
      ST_CPY: begin
        f_we = 1'b1;
        if (cnt == LW'(FRAG_LEN - 1)) state_next = ST_DONE;
      end
      ST_ENTRY: state_next = ST_CMP;
      ST_CMP: begin
        // end of chain, or last byte of this entry compared
        if (!cur_valid) state_next = ST_DONE;
        else if (rd_vld && cnt_d == LW'(FRAG_LEN - 1)) state_next = ST_LINK;
      end
      ST_LINK: state_next = mismatch ? ST_CMP : ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      qcnt <= '0;
      ecount <= '0;
      gpos <= '0;
      hits <= '0;
      coll <= '0;
      m_axis_tvalid <= 1'b0;
      cnt <= '0;
      cur_valid <= 1'b0;
      rd_vld <= 1'b0;
      for (int i = 0; i < FRAG_LEN; i++) gwin[i] <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          func <= s_axis_tuser;
          r_hit <= 1'b0;
          r_drop <= 1'b0;
          r_pos <= '0;
          r_entry <= '0;
          cnt <= '0;
          if (s_axis_tuser) begin
            for (int i = 0; i < FRAG_LEN - 1; i++) gwin[i] <= gwin[i+1];
            gwin[FRAG_LEN-1] <= s_axis_tdata;
            if (gpos != MAX36) gpos <= gpos + 1'b1;
          end else begin
            qbuf[qcnt[LW-1:0]] <= s_axis_tdata;
            qcnt <= qcnt + 1'b1;
          end
        end
        ST_QLOAD: if (!func && qcnt == CW'(FRAG_LEN)) begin
          qcnt <= '0;
          if (ecount >= EW'(POOL_SIZE)) r_drop <= 1'b1;
        end
        ST_HASH: cnt <= (cnt == LW'(FRAG_LEN - 1)) ? '0 : cnt + 1'b1;
        ST_HREAD: bkt <= hash_bkt;
        ST_HWAIT: ;
        ST_INSERT: if (h_rdata[PW] && coll != MAX11) coll <= coll + 1'b1;
        ST_CPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == LW'(FRAG_LEN - 1)) ecount <= ecount + 1'b1;
        end
        ST_ENTRY: begin
          // take chain head
          idx <= h_rdata[PW-1:0];
          cur_valid <= h_rdata[PW];
          mismatch <= 1'b0;
          rd_vld <= 1'b0;
          cnt <= '0;
        end
        ST_CMP: if (cur_valid) begin
          // advance the read address, compare the byte read last cycle
          if (cnt != LW'(FRAG_LEN - 1)) cnt <= cnt + 1'b1;
          cnt_d <= cnt;
          rd_vld <= 1'b1;
          if (rd_vld && !byte_eq) mismatch <= 1'b1;
        end
        ST_LINK: if (!mismatch) begin
          r_hit <= 1'b1;
          r_pos <= gpos - 36'(FRAG_LEN);
          r_entry <= idx;
          if (hits != MAX36) hits <= hits + 1'b1;
        end else begin
          // follow the link to the next entry
          idx <= l_rdata[PW-1:0];
          cur_valid <= l_rdata[PW];
          mismatch <= 1'b0;
          rd_vld <= 1'b0;
          cnt <= '0;
        end
        ST_DONE: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `CHK_IMPL(a_accept_idle, clk, rst, in_acc, state == ST_IDLE, "item taken while busy")
  `CHK_NEXT(a_valid_hold, clk, rst, out_stall, m_axis_tvalid, "result valid dropped")
  `CHK_NEXT(a_data_hold, clk, rst, out_stall, $stable(m_axis_tdata), "result data changed")
endmodule
